>>> rtl/core/joint_target_shaper_macros.svh
// Assertion macros shared by the joint target shaper RTL.
`ifndef JOINT_TARGET_SHAPER_MACROS_SVH
`define JOINT_TARGET_SHAPER_MACROS_SVH

// Plain check on every clock edge outside reset.
`define JTS_ASSERT_CLK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define JTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/jts_pkg.sv
// Shared constants, types and helper functions of the joint target shaper.
package jts_pkg;

  localparam int JOINT_COUNT = 12;
  localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP       = 2'd3;

  localparam logic [13:0] ACTION_GAIN_RST    = 14'd1024;
  localparam logic [12:0] TASK_GAIN_RST      = 13'd4096;
  localparam logic [14:0] POSITION_LIMIT_RST = 15'd4096;
  localparam logic [14:0] MAX_STEP_RST       = 15'd410;

  // Digit-serial multiplier geometry
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 4;
  localparam int MUL_B_W    = DIGIT_W * NUM_DIGITS;
  localparam int MUL_A_W    = 30;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = $clog2(NUM_DIGITS);

  // Product is Q.36, target is Q.12
  localparam int SHIFT   = 24;
  localparam int ROUND_W = PROD_W - SHIFT + 1;

  // Wide signed positions, enough for default +/- limit
  localparam int POS_W = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ROUND,
    ST_CLAMP,
    ST_SLEW,
    ST_DONE
  } state_t;

  function automatic logic signed [POS_W-1:0] sext_pos(input logic signed [15:0] x);
    sext_pos = {{(POS_W-16){x[15]}}, x};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [POS_W-1:0] x);
    logic signed [POS_W-1:0] hi_lim;
    logic signed [POS_W-1:0] lo_lim;
    hi_lim = sext_pos(16'sh7fff);
    lo_lim = sext_pos(16'sh8000);
    if (x > hi_lim) begin
      sat16 = 16'sh7fff;
    end else if (x < lo_lim) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = x[15:0];
    end
  endfunction

endpackage

>>> rtl/core/jts_smul.sv
// Digit-serial multiplier, one multiplier digit per cycle, MSB digit first.
module jts_smul
  import jts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  product,
  output logic               done
);

  localparam int PP_W = MUL_A_W + DIGIT_W;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   a_hold;
  logic [MUL_B_W-1:0]   b_sh;
  logic [PROD_W-1:0]    acc;
  logic [PP_W-1:0]      pp;

  assign pp      = PP_W'(a_hold) * PP_W'(b_sh[MUL_B_W-1 -: DIGIT_W]);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(NUM_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      b_sh   <= b;
      acc    <= '0;
    end else if (busy) begin
      acc  <= {acc[PROD_W-DIGIT_W-1:0], DIGIT_W'(0)} + PROD_W'(pp);
      b_sh <= b_sh << DIGIT_W;
    end
  end

endmodule

>>> rtl/core/joint_target_shaper.sv
// Joint target shaper: scale, clamp and rate-limit a policy action per joint.
//
// Items come in on item_valid/item_stall; one result per item leaves on
// result_valid/result_stall. A transfer happens on a clock edge with valid
// high and stall low. Configuration is written through cfg_write, cfg_index
// and cfg_data; the user must do so only while no item is in flight, as the
// block does not enforce it. A load item (action = 0) sets the default and
// last target of an in-range joint; its result is registered from the done
// state once the output register is free. A shape item runs two 4-digit
// serial multiplies (action by action_gain, then by task_gain), a rounding
// state, a clamp state and a slew state, then registers its result from the
// done state in the same way. The next item is taken the cycle after the
// result is registered. Most of a shape item's time is in the multiplier.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the finished item waits in its last state until the
// output register is free, and item_stall stays high meanwhile.
// Synchronous reset restores the register defaults, zeroes all default and
// last targets and empties the output register.
`include "joint_target_shaper_macros.svh"

module joint_target_shaper
  import jts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 action,
  input  logic [3:0]           joint,
  input  logic signed [15:0]   value,
  input  logic                 not_finite,
  input  logic                 commit,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [3:0]           out_joint,
  output logic signed [15:0]   target,
  output logic                 published,
  output logic                 clamped,
  output logic                 slew_limited,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [14:0]          cfg_data
);

  state_t state, state_next;

  logic [13:0] action_gain;
  logic [12:0] task_gain;
  logic [14:0] position_limit;
  logic [14:0] max_step;

  logic signed [15:0] def_pos  [JOINT_COUNT];
  logic signed [15:0] last_pos [JOINT_COUNT];

  // latched item
  logic               item_shape;
  logic [3:0]         item_joint;
  logic signed [15:0] item_value;
  logic               item_nf;
  logic               item_commit;
  logic               item_ok;
  logic [JIDX_W-1:0]  jidx;

  logic               item_fire;
  logic               finish;

  // multiplier
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_product;
  logic               mul_done;
  logic [15:0]        value_mag;

  // datapath
  logic [ROUND_W-1:0]      rnd;
  logic signed [15:0]      scaled, scaled_next;
  logic signed [15:0]      shaped, clamp_out, slew_out;
  logic                    clamp_flag, clamp_hit;
  logic                    slew_flag, slew_hit;
  logic signed [POS_W-1:0] def_ext, sum, lo, hi, lim;
  logic signed [POS_W-1:0] last_ext, shaped_ext, diff, step, slew_t;

  assign item_fire = item_valid && !item_stall;
  assign item_stall = rst || (state != ST_IDLE);
  assign jidx = JIDX_W'(item_joint);
  assign value_mag = value[15] ? (~value + 16'd1) : value;

  jts_smul u_smul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_product),
    .done    (mul_done)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = mul_product[MUL_A_W-1:0];
    mul_b      = MUL_B_W'(task_gain);
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        mul_a = MUL_A_W'(value_mag);
        mul_b = MUL_B_W'(action_gain);
        if (item_fire) begin
          mul_start  = action;
          state_next = action ? ST_MUL1 : ST_DONE;
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_SLEW;
      ST_SLEW:  state_next = ST_DONE;
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      action_gain    <= ACTION_GAIN_RST;
      task_gain      <= TASK_GAIN_RST;
      position_limit <= POSITION_LIMIT_RST;
      max_step       <= MAX_STEP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTION_GAIN:    action_gain    <= cfg_data[13:0];
        REG_TASK_GAIN:      task_gain      <= cfg_data[12:0];
        REG_POSITION_LIMIT: position_limit <= cfg_data[14:0];
        REG_MAX_STEP:       max_step       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (item_fire) begin
      item_shape  <= action;
      item_joint  <= joint;
      item_value  <= value;
      item_nf     <= not_finite;
      item_commit <= commit;
      item_ok     <= (int'(joint) < JOINT_COUNT);
    end
  end

  // round to nearest, ties away from zero, then saturate the magnitude
  always_comb begin
    rnd = {1'b0, mul_product[PROD_W-1:SHIFT]} + ROUND_W'(mul_product[SHIFT-1]);
    if (item_nf) begin
      scaled_next = '0;
    end else if (item_value[15]) begin
      scaled_next = (rnd > ROUND_W'(32768)) ? 16'sh8000 : (~rnd[15:0] + 16'd1);
    end else begin
      scaled_next = (rnd > ROUND_W'(32767)) ? 16'sh7fff : rnd[15:0];
    end
  end

  // position clamp around the default
  always_comb begin
    def_ext   = item_ok ? sext_pos(def_pos[jidx]) : '0;
    lim       = {{(POS_W-15){1'b0}}, position_limit};
    sum       = def_ext + sext_pos(scaled);
    lo        = def_ext - lim;
    hi        = def_ext + lim;
    clamp_hit = 1'b0;
    if (sum < lo) begin
      clamp_out = sat16(lo);
      clamp_hit = 1'b1;
    end else if (sum > hi) begin
      clamp_out = sat16(hi);
      clamp_hit = 1'b1;
    end else begin
      clamp_out = sat16(sum);
    end
  end

  // step limit against the last committed target
  always_comb begin
    last_ext   = sext_pos(last_pos[jidx]);
    shaped_ext = sext_pos(shaped);
    step       = {{(POS_W-15){1'b0}}, max_step};
    diff       = shaped_ext - last_ext;
    slew_hit   = 1'b0;
    slew_t     = shaped_ext;
    if (item_commit && item_ok) begin
      if (diff > step) begin
        slew_t   = last_ext + step;
        slew_hit = 1'b1;
      end else if (diff < -step) begin
        slew_t   = last_ext - step;
        slew_hit = 1'b1;
      end
    end
    slew_out = sat16(slew_t);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_ROUND: scaled <= scaled_next;
      ST_CLAMP: begin
        shaped     <= clamp_out;
        clamp_flag <= clamp_hit;
      end
      ST_SLEW: begin
        shaped    <= slew_out;
        slew_flag <= slew_hit;
      end
      default: ;
    endcase
  end

  // per-joint state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        def_pos[i]  <= '0;
        last_pos[i] <= '0;
      end
    end else if (finish && item_ok) begin
      if (!item_shape) begin
        def_pos[jidx]  <= item_value;
        last_pos[jidx] <= item_value;
      end else if (item_commit) begin
        last_pos[jidx] <= shaped;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_joint    <= item_joint;
      target       <= item_shape ? shaped : item_value;
      published    <= item_shape && item_commit && item_ok;
      clamped      <= item_shape && clamp_flag;
      slew_limited <= item_shape && slew_flag;
    end
  end

  `JTS_ASSERT_IMPL(a_mul_done_in_mul, mul_done,
                   (state == ST_MUL1) || (state == ST_MUL2),
                   "multiplier finished outside a multiply state")
  `JTS_ASSERT_NEXT(a_done_holds, (state == ST_DONE) && result_valid && result_stall,
                   state == ST_DONE, "finished item left while output was blocked")
  `JTS_ASSERT_IMPL(a_pub_joint_ok, result_valid && published,
                   int'(out_joint) < JOINT_COUNT,
                   "published a target for a joint out of range")
  `JTS_ASSERT_IMPL(a_slew_needs_pub, result_valid && slew_limited, published,
                   "step limited without commit")

endmodule
